[rtl/lbps_pkg.sv]
// ----------------------------------------------------------------------------
// lbps_pkg
// Shared types, codes and helpers of the LED blink pattern scheduler.
// ----------------------------------------------------------------------------
package lbps_pkg;

	// command codes on the input channel
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	// classified operations handed from front to back
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// configuration register indexes
	localparam logic CFG_LEDS_IN_USE  = 1'b0;
	localparam logic CFG_MAX_INTERVAL = 1'b1;

	localparam logic [7:0] REPEAT_FOREVER = 8'hFF;

	// one queued word between front and back
	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  led;
		logic [3:0]  step;
		logic [15:0] dur;
		logic [4:0]  len;
		logic [7:0]  rep;
		logic        lvl;
	} item_t;

	// wrapping compare: a is at or before b
	function automatic logic not_after(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d == 32'd0) || d[31];
	endfunction

endpackage

[rtl/lbps_if.sv]
// ----------------------------------------------------------------------------
// lbps channel interfaces
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lbps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [3:0]  led_index;
	logic [3:0]  step_index;
	logic [15:0] duration;
	logic [4:0]  pattern_length;
	logic [7:0]  repeats;
	logic        initial_level;

	modport source(output valid, command, led_index, step_index, duration,
		pattern_length, repeats, initial_level, input ready);
	modport sink(input valid, command, led_index, step_index, duration,
		pattern_length, repeats, initial_level, output ready);
endinterface

interface lbps_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  led_levels;
	logic        blinking;
	logic [15:0] next_delay;

	modport source(output valid, led_levels, blinking, next_delay, input ready);
	modport sink(input valid, led_levels, blinking, next_delay, output ready);
endinterface

interface lbps_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/led_blink_pattern_scheduler.sv]
// ----------------------------------------------------------------------------
// led_blink_pattern_scheduler
// Blink pattern sequencer for several LEDs with a shared duration store.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  cmd     | in  | valid/ready   | command, led_index, step_index, duration,
//          |     |               | pattern_length, repeats, initial_level
//  res     | out | valid/ready   | led_levels, blinking, next_delay
//  cfg     | in  | valid/ready   | index, data (ready always high)
//
//  A command word passes the states idle, start (start commands only), init,
//  one check per LED in use plus write-back and compare for a LED whose step
//  expires (duration store read), and finish. Results leave through an output
//  register; a full one stalls the finish state, and a two-word queue takes
//  commands while a result waits. Reset clears all LED state, the time counter
//  and the configuration; the duration store is not cleared.
module led_blink_pattern_scheduler #(
	parameter int NUM_LEDS      = 8,
	parameter int MAX_STEPS     = 16,
	parameter int DURATION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lbps_in_if.sink     cmd,
	lbps_out_if.source  res,
	lbps_cfg_if.sink    cfg
);
	import lbps_pkg::*;

	logic [3:0]  leds_q;
	logic [15:0] maxi_q;
	logic [4:0]  leds_eff;
	item_t       q_item;
	logic        q_valid, q_pop;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leds_q <= 4'd8;
			maxi_q <= 16'hFFFF;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LEDS_IN_USE:  leds_q <= cfg.data[3:0];
				CFG_MAX_INTERVAL: maxi_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// LEDs in use, saturated to the LEDs present
	assign leds_eff = ({1'b0, leds_q} > 5'(NUM_LEDS)) ? 5'(NUM_LEDS) : {1'b0, leds_q};

	lbps_front #(.NUM_LEDS(NUM_LEDS), .MAX_STEPS(MAX_STEPS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.leds_eff(leds_eff),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	lbps_back #(
		.NUM_LEDS     (NUM_LEDS),
		.MAX_STEPS    (MAX_STEPS),
		.DURATION_BITS(DURATION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_item      (q_item),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.leds_eff    (leds_eff),
		.max_interval(maxi_q),
		.res         (res)
	);
endmodule

[rtl/lbps_ram.sv]
// ----------------------------------------------------------------------------
// lbps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/lbps_front.sv]
// ----------------------------------------------------------------------------
// lbps_front
// Accepts command words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lbps_front #(
	parameter int NUM_LEDS  = 8,
	parameter int MAX_STEPS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	lbps_in_if.sink        cmd,
	input  logic [4:0]     leds_eff,
	output lbps_pkg::item_t q_item,
	output logic           q_valid,
	input  logic           q_pop
);
	import lbps_pkg::*;

	localparam int QDEPTH = 2;

	item_t      cls;
	item_t      mem_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	// classify the incoming word
	always_comb begin
		cls      = '0;
		cls.led  = cmd.led_index;
		cls.step = cmd.step_index;
		cls.dur  = cmd.duration;
		cls.rep  = cmd.repeats;
		cls.lvl  = cmd.initial_level;
		cls.op   = OP_NONE;
		if (cmd.pattern_length == 5'd0) begin
			cls.len = 5'd1;
		end else if ({2'b00, cmd.pattern_length} > 7'(MAX_STEPS)) begin
			cls.len = 5'(MAX_STEPS);
		end else begin
			cls.len = cmd.pattern_length;
		end
		unique case (cmd.command)
			CMD_TICK: cls.op = OP_TICK;
			CMD_LOAD: begin
				if ({1'b0, cmd.led_index} < 5'(NUM_LEDS)
					&& {3'b000, cmd.step_index} < 7'(MAX_STEPS)) begin
					cls.op = OP_LOAD;
				end
			end
			CMD_START: begin
				if ({1'b0, cmd.led_index} < leds_eff) begin
					cls.op = OP_START;
				end
			end
			default: cls.op = OP_NONE;
		endcase
	end

	assign cmd.ready = (cnt_q != 2'(QDEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = mem_q[rp_q];

	// two-word queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= cls;
		end
	end
endmodule

[rtl/lbps_back.sv]
// ----------------------------------------------------------------------------
// lbps_back
// Executes queued words: applies the command, services LEDs one per pass,
// and registers the result word.
// ----------------------------------------------------------------------------
module lbps_back #(
	parameter int NUM_LEDS      = 8,
	parameter int MAX_STEPS     = 16,
	parameter int DURATION_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lbps_pkg::item_t q_item,
	input  logic            q_valid,
	output logic            q_pop,
	input  logic [4:0]      leds_eff,
	input  logic [15:0]     max_interval,
	lbps_out_if.source      res
);
	import lbps_pkg::*;

	localparam int LI_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int POS_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int SZ_W  = $clog2(MAX_STEPS + 1);
	localparam int DEPTH = NUM_LEDS * MAX_STEPS;
	localparam int AW    = $clog2(DEPTH);
	localparam int LV_N  = (NUM_LEDS < 8) ? NUM_LEDS : 8;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_INIT  = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_WB    = 3'd4;
	localparam logic [2:0] ST_CMP   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]         state_q;
	item_t              cur_q;
	logic [LI_W-1:0]    idx_q;
	logic [31:0]        time_q;
	logic [31:0]        near_q;
	logic               any_q;

	logic [31:0]        dl_q   [NUM_LEDS];
	logic [POS_W-1:0]   pos_q  [NUM_LEDS];
	logic [7:0]         rep_q  [NUM_LEDS];
	logic               slvl_q [NUM_LEDS];
	logic [SZ_W-1:0]    size_q [NUM_LEDS];
	logic               lvl_q  [NUM_LEDS];

	logic [7:0]         res_levels_q;
	logic               res_any_q;
	logic [15:0]        res_delay_q;
	logic               res_valid_q;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic [DURATION_BITS-1:0] ram_wdata, ram_rdata;

	logic [SZ_W-1:0]    nxt;
	logic               wrap;
	logic [POS_W-1:0]   newpos;
	logic               last;
	logic               cur_exp, cur_near;
	logic [LI_W-1:0]    sled;
	logic [31:0]        dly;
	logic [15:0]        delay16;
	logic [7:0]         levels;
	logic               out_free;

	function automatic logic [AW-1:0] addr_of(input logic [LI_W-1:0] led,
		input logic [POS_W-1:0] pos);
		return AW'(led) * AW'(MAX_STEPS) + AW'(pos);
	endfunction

	lbps_ram #(.WIDTH(DURATION_BITS), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// step advance of the LED under service
	assign nxt      = SZ_W'(pos_q[idx_q]) + SZ_W'(1);
	assign wrap     = (nxt == size_q[idx_q]);
	assign newpos   = wrap ? '0 : POS_W'(nxt);
	assign last     = (5'(idx_q) + 5'd1) == leds_eff;
	assign cur_exp  = not_after(dl_q[idx_q], time_q);
	assign cur_near = not_after(dl_q[idx_q], near_q);
	assign sled     = cur_q.led[LI_W-1:0];

	// duration store access
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign ram_we    = q_pop && (q_item.op == OP_LOAD);
	assign ram_waddr = addr_of(q_item.led[LI_W-1:0], POS_W'(q_item.step));
	assign ram_wdata = DURATION_BITS'(q_item.dur);
	assign ram_raddr = (state_q == ST_IDLE) ? addr_of(q_item.led[LI_W-1:0], '0)
		: addr_of(idx_q, newpos);

	// result word
	assign dly     = near_q - time_q;
	assign delay16 = !any_q ? 16'd0 : (((dly == 32'd0) || dly[31]) ? 16'd1 : dly[15:0]);
	always_comb begin
		levels = '0;
		for (int j = 0; j < LV_N; j++) begin
			levels[j] = lvl_q[j];
		end
	end
	assign out_free = !res_valid_q || res.ready;

	assign res.valid      = res_valid_q;
	assign res.led_levels = res_levels_q;
	assign res.blinking   = res_any_q;
	assign res.next_delay = res_delay_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			time_q      <= '0;
			near_q      <= '0;
			any_q       <= 1'b0;
			res_valid_q <= 1'b0;
			cur_q       <= '0;
			for (int k = 0; k < NUM_LEDS; k++) begin
				dl_q[k]   <= '0;
				pos_q[k]  <= '0;
				rep_q[k]  <= '0;
				slvl_q[k] <= 1'b0;
				size_q[k] <= SZ_W'(1);
				lvl_q[k]  <= 1'b0;
			end
		end else begin
			// output register: load on finish, clear once taken
			if (state_q == ST_FIN && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cur_q <= q_item;
						if (q_item.op == OP_TICK) begin
							time_q <= time_q + 32'd1;
						end
						state_q <= (q_item.op == OP_START) ? ST_START : ST_INIT;
					end
				end
				ST_START: begin
					size_q[sled] <= SZ_W'(cur_q.len);
					rep_q[sled]  <= cur_q.rep;
					slvl_q[sled] <= cur_q.lvl;
					pos_q[sled]  <= '0;
					lvl_q[sled]  <= cur_q.lvl;
					dl_q[sled]   <= time_q + 32'(ram_rdata);
					state_q      <= ST_INIT;
				end
				ST_INIT: begin
					near_q  <= time_q + 32'(max_interval);
					any_q   <= 1'b0;
					idx_q   <= '0;
					state_q <= (leds_eff == 5'd0) ? ST_FIN : ST_CHK;
				end
				ST_CHK: begin
					if (rep_q[idx_q] != 8'd0) begin
						any_q <= 1'b1;
					end
					if (rep_q[idx_q] != 8'd0 && cur_exp) begin
						pos_q[idx_q] <= newpos;
						if (rep_q[idx_q] != REPEAT_FOREVER) begin
							rep_q[idx_q] <= rep_q[idx_q] - 8'(wrap);
						end
						lvl_q[idx_q] <= slvl_q[idx_q] ^ newpos[0];
						state_q      <= ST_WB;
					end else begin
						if (rep_q[idx_q] != 8'd0 && cur_near) begin
							near_q <= dl_q[idx_q];
						end
						if (last) begin
							state_q <= ST_FIN;
						end else begin
							idx_q <= idx_q + LI_W'(1);
						end
					end
				end
				ST_WB: begin
					dl_q[idx_q] <= time_q + 32'(ram_rdata);
					state_q     <= ST_CMP;
				end
				ST_CMP: begin
					if (cur_near) begin
						near_q <= dl_q[idx_q];
					end
					if (last) begin
						state_q <= ST_FIN;
					end else begin
						idx_q   <= idx_q + LI_W'(1);
						state_q <= ST_CHK;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			res_levels_q <= levels;
			res_any_q    <= any_q;
			res_delay_q  <= delay16;
		end
	end
endmodule

[rtl/lbps_checker.sv]
// ----------------------------------------------------------------------------
// lbps_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lbps_checker #(
	parameter int NUM_LEDS = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [7:0]  res_levels,
	input logic        res_any,
	input logic [15:0] res_delay
);
	localparam logic [7:0] LV_MASK = (NUM_LEDS >= 8) ? 8'h00 : ~8'((1 << NUM_LEDS) - 1);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_levels)
			&& $stable(res_any) && $stable(res_delay))
		else $error("result word changed while stalled");

	// active implies a nonzero delay
	a_act: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_any |-> res_delay != 16'd0)
		else $error("active result with zero delay");

	// idle implies zero delay
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_any |-> res_delay == 16'd0)
		else $error("idle result with nonzero delay");

	// absent LEDs stay dark
	a_lv: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_levels & LV_MASK) == 8'h00)
		else $error("level set for absent LED");
endmodule

bind led_blink_pattern_scheduler lbps_checker #(.NUM_LEDS(NUM_LEDS)) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_levels(res.led_levels),
	.res_any   (res.blinking),
	.res_delay (res.next_delay)
);
